// ===== src/hash_table_linear_probe_assert.svh =====
// assertion macros for the hash table block
`ifndef HASH_TABLE_LINEAR_PROBE_ASSERT_SVH
`define HASH_TABLE_LINEAR_PROBE_ASSERT_SVH
`ifndef SYNTHESIS
`define HTLP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HTLP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HTLP_ASSERT(label, clk, rst_n, prop, msg)
`define HTLP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/htlp_pkg.sv =====
`default_nettype none
package htlp_pkg;
  localparam int unsigned SlotsDefault = 1024;
  localparam int unsigned CountW = 11;
  localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001B3;
  localparam logic [CountW-1:0] LoadLimitReset = 11'd512;

  typedef enum logic [1:0] {
    CmdGet = 2'd0,
    CmdPut = 2'd1,
    CmdDel = 2'd2,
    CmdNop = 2'd3
  } cmd_e;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StAbsent = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  // hash unit status toward the control
  typedef struct packed {
    logic busy;
    logic done;
  } hash_stat_t;
endpackage
`default_nettype wire

// ===== src/hash_table_linear_probe.sv =====
// hash table with linear probing, 64-bit keys and values
// input word on s_axis: cmd, lookup_key, new_value; one result word on
// m_axis: status, found_value, entries_held.
// load_limit is written through cfg_we_i/cfg_wdata_i. the user must write it
// only while the block idles; the block itself does not enforce this.
// one item at a time: s_axis_tready is high only when the block is idle and
// the output register is free.
// steps: fnv hash (eight multiplies, one a cycle, and a done strobe), then a
// synchronous read and a compare per probed slot, plus a write for a change
// and a step to present the result; a nop, or a get or del on an empty table,
// goes from the hash straight to the result.
// the next word can be taken in the cycle after the result leaves.
// the slot store is one memory of key, value and flags with a registered read.
// after reset a clearing pass walks every slot to clear the used and
// tombstone flags, while no word is accepted.
// if m_axis_tready is low the result holds in the output register and no
// new word is taken until it leaves.
`default_nettype none
`include "hash_table_linear_probe_assert.svh"
module hash_table_linear_probe #(
  parameter int unsigned SLOTS = htlp_pkg::SlotsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [10:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [1:0] cmd, [65:2] lookup_key, [129:66] new_value, zero fill
  input  wire logic [135:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [1:0] status, [65:2] found_value, [76:66] entries_held, zero fill
  output logic [79:0]       m_axis_tdata
);
  import htlp_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);

  typedef enum logic [2:0] {
    SClear, SIdle, SHash, SRead, SCheck, SWrite, SOut
  } state_e;

  // slot word: used, tombstone, key, value
  typedef struct packed {
    logic        used;
    logic        tomb;
    logic [63:0] key;
    logic [63:0] value;
  } slot_t;

  slot_t           mem_q [SLOTS];
  slot_t           rd_q, wr_d;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;

  state_e          state_q;
  logic [CountW-1:0] limit_q, count_q;
  logic [1:0]      cmd_q;
  logic [63:0]     key_q, val_q;
  logic [IdxW-1:0] idx_q, tomb_q, tgt_q;
  logic [IdxW:0]   steps_q;
  logic            have_tomb_q, hit_q, stored_q;
  logic            out_v_q;
  logic [1:0]      st_q;
  logic [63:0]     fv_q;
  hash_stat_t      hstat;
  logic [63:0]     hash;
  logic            hstart;
  logic            empty, match;

  htlp_hash u_hash (
    .clk_i, .rst_ni, .start_i(hstart), .key_i(s_axis_tdata[65:2]),
    .stat_o(hstat), .hash_o(hash)
  );

  assign s_axis_tready = (state_q == SIdle) && !out_v_q;
  assign hstart = s_axis_tvalid && s_axis_tready;
  assign empty  = !rd_q.used && !rd_q.tomb;
  assign match  = rd_q.used && (rd_q.key == key_q);

  // memory port
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wr_d;
    rd_q <= mem_q[raddr];
  end

  assign raddr = idx_q;

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wr_d  = rd_q;
    if (state_q == SClear) begin
      we   = 1'b1;
      wr_d = '0;
    end else if (state_q == SWrite) begin
      we = 1'b1;
      if (hit_q && cmd_q == CmdPut) begin
        wr_d.value = val_q;
      end else if (hit_q) begin
        wr_d.used = 1'b0;
        wr_d.tomb = 1'b1;
      end else begin
        waddr = tgt_q;
        wr_d  = '{used: 1'b1, tomb: 1'b0, key: key_q, value: val_q};
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      limit_q     <= LoadLimitReset;
      count_q     <= '0;
      idx_q       <= '0;
      out_v_q     <= 1'b0;
      steps_q     <= '0;
      have_tomb_q <= 1'b0;
      hit_q       <= 1'b0;
      stored_q    <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        SClear: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == IdxW'(SLOTS - 1)) state_q <= SIdle;
        end
        SIdle: begin
          if (hstart) begin
            state_q     <= SHash;
            have_tomb_q <= 1'b0;
            hit_q       <= 1'b0;
            stored_q    <= 1'b0;
            steps_q     <= '0;
          end
        end
        SHash: begin
          if (hstat.done) begin
            idx_q <= hash[IdxW-1:0];
            if (cmd_q == CmdNop ||
                (count_q == '0 && (cmd_q == CmdGet || cmd_q == CmdDel))) begin
              state_q <= SOut;
            end else begin
              state_q <= SRead;
            end
          end
        end
        SRead: state_q <= SCheck;
        SCheck: begin
          if (empty) begin
            tgt_q    <= have_tomb_q ? tomb_q : idx_q;
            state_q  <= (cmd_q == CmdPut && count_q < limit_q) ? SWrite : SOut;
          end else if (match) begin
            hit_q   <= 1'b1;
            state_q <= (cmd_q == CmdGet) ? SOut : SWrite;
          end else begin
            if (rd_q.tomb && !have_tomb_q) begin
              have_tomb_q <= 1'b1;
              tomb_q      <= idx_q;
            end
            if (steps_q == (IdxW+1)'(SLOTS - 1)) begin
              tgt_q    <= have_tomb_q ? tomb_q : idx_q;
              state_q  <= (cmd_q == CmdPut && count_q < limit_q &&
                           (have_tomb_q || rd_q.tomb)) ? SWrite : SOut;
            end else begin
              steps_q <= steps_q + 1'b1;
              idx_q   <= (idx_q == IdxW'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
              state_q <= SRead;
            end
          end
        end
        SWrite: begin
          stored_q <= 1'b1;
          if (!hit_q) count_q <= count_q + 1'b1;
          else if (cmd_q == CmdDel) count_q <= count_q - 1'b1;
          state_q <= SOut;
        end
        SOut: begin
          out_v_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (hstart) begin
      cmd_q <= s_axis_tdata[1:0];
      key_q <= s_axis_tdata[65:2];
      val_q <= s_axis_tdata[129:66];
    end
    if (state_q == SOut) begin
      fv_q <= '0;
      if (hit_q) begin
        st_q <= StOk;
        if (cmd_q == CmdGet) fv_q <= rd_q.value;
      end else if (cmd_q == CmdPut) begin
        st_q <= stored_q ? StOk : StFull;
      end else begin
        st_q <= StAbsent;
      end
    end
  end

  // result word on m_axis
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'd0, count_q, fv_q, st_q};

  `HTLP_ASSERT(a_one_in_flight, clk_i, rst_ni, !(s_axis_tready && state_q != SIdle), "ready outside idle")
  `HTLP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_v_q && !m_axis_tready, out_v_q, "result dropped")
  `HTLP_ASSERT(a_count_cap, clk_i, rst_ni, count_q <= CountW'(SLOTS), "count beyond slots")
  `HTLP_ASSERT_NEXT(a_hash_seq, clk_i, rst_ni, hstart, state_q == SHash, "hash not started")
endmodule
`default_nettype wire

// ===== src/htlp_hash.sv =====
`default_nettype none
// fnv-1a over eight key bytes, one byte and one multiply per cycle
module htlp_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] key_i,
  output htlp_pkg::hash_stat_t stat_o,
  output logic [63:0]      hash_o
);
  import htlp_pkg::*;

  logic [63:0] key_q, h_q;
  logic [2:0]  byte_q;
  logic        busy_q, done_q;
  logic [63:0] mixed;

  assign mixed = h_q ^ {56'd0, key_q[7:0]};

  // byte step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      byte_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        byte_q <= '0;
      end else if (busy_q) begin
        byte_q <= byte_q + 3'd1;
        if (byte_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
      h_q   <= FnvBasis;
    end else if (busy_q) begin
      key_q <= {8'd0, key_q[63:8]};
      h_q   <= mixed * FnvPrime;
    end
  end

  assign hash_o = h_q;
  assign stat_o = '{busy: busy_q, done: done_q};
endmodule
`default_nettype wire

// ===== test/hash_table_linear_probe_checker.sv =====
`default_nettype none
module hash_table_linear_probe_checker
  import htlp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [10:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [79:0]  m_axis_tdata,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       words_checked_o,
  output int unsigned       get_hits_o,
  output int unsigned       refusals_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = SlotsDefault;

  // last field sits in the lowest bits, as on m_axis_tdata
  typedef struct packed {
    logic [CountW-1:0] entries_held;
    logic [63:0]       found_value;
    logic [1:0]        status;
  } lookup_result_t;

  // shadow copy of the table
  logic [63:0]       shadow_keys   [Slots];
  logic [63:0]       shadow_values [Slots];
  bit                shadow_used   [Slots];
  bit                shadow_tomb   [Slots];
  logic [CountW-1:0] shadow_count;
  logic [CountW-1:0] shadow_limit;

  lookup_result_t awaited_results[$];

  function automatic logic [63:0] fnv1a64(input logic [63:0] key);
    logic [63:0] h;
    h = FnvBasis;
    for (int b = 0; b < 8; b++) begin
      h = (h ^ {56'd0, key[8*b +: 8]}) * FnvPrime;
    end
    return h;
  endfunction

  // one table operation on the shadow copy, returns the expected word
  function automatic lookup_result_t table_step(input cmd_e cmd, input logic [63:0] key,
                                                input logic [63:0] value);
    lookup_result_t res;
    int unsigned home, idx, hit_slot, free_slot;
    bit hit, have_free, have_tomb;
    res = '{status: StAbsent, found_value: '0, entries_held: '0};
    hit = 0;
    have_free = 0;
    have_tomb = 0;
    hit_slot = 0;
    free_slot = 0;
    home = 32'(fnv1a64(key) % Slots);
    // probe walk: first tombstone wins as insert target, empty slot stops
    for (int p = 0; p < Slots; p++) begin
      idx = (home + p) % Slots;
      if (!shadow_used[idx] && !shadow_tomb[idx]) begin
        if (!have_tomb) free_slot = idx;
        have_free = 1;
        break;
      end
      if (shadow_tomb[idx]) begin
        if (!have_tomb) begin
          have_tomb = 1;
          free_slot = idx;
          have_free = 1;
        end
      end else if (shadow_keys[idx] == key) begin
        hit = 1;
        hit_slot = idx;
        break;
      end
    end
    case (cmd)
      CmdGet: begin
        if (shadow_count != 0 && hit) begin
          res.status = StOk;
          res.found_value = shadow_values[hit_slot];
        end
      end
      CmdPut: begin
        if (hit) begin
          shadow_values[hit_slot] = value;
          res.status = StOk;
        end else if (shadow_count >= shadow_limit || !have_free) begin
          res.status = StFull;
        end else begin
          shadow_keys[free_slot] = key;
          shadow_values[free_slot] = value;
          shadow_used[free_slot] = 1;
          shadow_tomb[free_slot] = 0;
          shadow_count++;
          res.status = StOk;
        end
      end
      CmdDel: begin
        if (shadow_count != 0 && hit) begin
          shadow_used[hit_slot] = 0;
          shadow_tomb[hit_slot] = 1;
          shadow_count--;
          res.status = StOk;
        end
      end
      default: ;
    endcase
    res.entries_held = shadow_count;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = awaited_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        shadow_used[i] = 0;
        shadow_tomb[i] = 0;
      end
      shadow_count = '0;
      shadow_limit = LoadLimitReset;
      awaited_results.delete();
      fail_count_o = 0;
      words_checked_o = 0;
      get_hits_o = 0;
      refusals_o = 0;
    end else begin
      if (cfg_we_i) shadow_limit = cfg_wdata_i;
      // outgoing word checked before the incoming one is predicted
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[76:0];
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected word", {48'd0, m_axis_tdata[79:64]},
                          m_axis_tdata[63:0]);
        end else begin
          want = awaited_results.pop_front();
          words_checked_o++;
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.found_value != want.found_value)
            report_mismatch("found_value", got.found_value, want.found_value);
          if (got.entries_held != want.entries_held)
            report_mismatch("entries_held", 64'(got.entries_held),
                            64'(want.entries_held));
          if (m_axis_tdata[79:77] != '0)
            report_mismatch("fill bits", 64'(m_axis_tdata[79:77]), 64'd0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = table_step(cmd_e'(s_axis_tdata[1:0]), s_axis_tdata[65:2],
                          s_axis_tdata[129:66]);
        if (want.status == StOk && s_axis_tdata[1:0] == CmdGet) get_hits_o++;
        if (want.status == StFull) refusals_o++;
        awaited_results.push_back(want);
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/hash_table_linear_probe_test.sv =====
`default_nettype none
module hash_table_linear_probe_test;
  import htlp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 12000000;
  localparam int unsigned KeyPoolSize = 48;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [10:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [79:0]  m_axis_tdata;

  int unsigned fail_count, pending, words_checked, get_hits, refusals;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  int unsigned words_sent = 0;
  logic [63:0] key_pool[KeyPoolSize];

  hash_table_linear_probe u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  hash_table_linear_probe_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending),
    .words_checked_o(words_checked), .get_hits_o(get_hits), .refusals_o(refusals)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // cycle watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver backpressure; its mood, a stall percentage of 0, 35 or 70, is redrawn as cycle_count runs
  always @(negedge clk_i) begin
    if (cycle_count % 64 == 0) stall_pct <= $urandom_range(0, 2) * 35;
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // one word on s_axis, called right after a rising edge
  task automatic send_word(input cmd_e cmd, input logic [63:0] key, input logic [63:0] value);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, value, key, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // drain, then write load_limit while the block idles
  task automatic write_limit(input logic [10:0] limit);
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= limit;
    @(negedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_ops(input int unsigned count);
    int unsigned r;
    cmd_e cmd;
    logic [63:0] key;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      cmd = (r < 40) ? CmdPut : (r < 70) ? CmdGet : (r < 93) ? CmdDel : CmdNop;
      key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KeyPoolSize - 1)]
                                          : {$urandom, $urandom};
      send_word(cmd, key, {$urandom, $urandom});
    end
  endtask

  initial begin
    logic [63:0] miss_key;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KeyPoolSize; i++) key_pool[i] = {$urandom, $urandom};
    miss_key = {$urandom, $urandom};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty table, overwrite, tombstone reuse, unused command
    send_word(CmdGet, key_pool[0], '1);
    send_word(CmdDel, key_pool[0], '0);
    send_word(CmdNop, key_pool[1], '1);
    send_word(CmdPut, key_pool[0], '0);
    send_word(CmdPut, key_pool[1], '1);
    send_word(CmdGet, key_pool[0], '0);
    send_word(CmdGet, key_pool[1], '0);
    send_word(CmdPut, key_pool[0], '1);
    send_word(CmdGet, key_pool[0], '0);
    send_word(CmdGet, miss_key, '0);
    send_word(CmdDel, miss_key, '0);
    send_word(CmdDel, key_pool[0], '0);
    send_word(CmdGet, key_pool[0], '0);
    send_word(CmdPut, key_pool[0], 64'h5);
    send_word(CmdGet, key_pool[0], '0);
    send_word(CmdNop, '1, '1);

    // load limit reached: new key refused, overwrite still allowed
    write_limit(11'd1);
    send_word(CmdPut, key_pool[2], 64'h77);
    send_word(CmdPut, key_pool[1], 64'h99);
    send_word(CmdGet, key_pool[1], '0);
    send_word(CmdDel, key_pool[1], '0);
    send_word(CmdPut, key_pool[2], 64'h77);

    write_limit(11'd1024);
    random_ops(40);
    write_limit(11'd5);
    random_ops(15);

    // fill every slot so the walk finds no free slot
    write_limit(11'h7FF);
    for (int i = 0; i < 1030; i++)
      send_word(CmdPut, {16'($urandom_range(0, 16'hFFFF)), 16'hC3A5, 32'(i)},
                {$urandom, $urandom});
    random_ops(10);

    write_limit(11'd512);
    random_ops(10);

    @(negedge clk_i);
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("sent %0d words, checked %0d results: %0d get hits, %0d refused puts",
             words_sent, words_checked, get_hits, refusals);
    $display("load limits 512, 1, 1024, 5, 2047 and a full table were covered");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
